// ===== rtl/core/slipd_pkg.sv =====
// slipd_pkg: shared types and constants for the slip deframer
// framing byte codes, frame size limit, result kinds and frame phases
// no dependencies
package slipd_pkg;

  localparam int MAX_FRAME = 2048;
  localparam int CNT_W     = $clog2(MAX_FRAME);

  localparam logic [7:0] BYTE_END     = 8'o300;
  localparam logic [7:0] BYTE_ESC     = 8'o333;
  localparam logic [7:0] BYTE_ESC_END = 8'o334;
  localparam logic [7:0] BYTE_ESC_ESC = 8'o335;

  localparam int MODE_FRAMES_ONLY_BIT = 0;
  localparam int MODE_HIDE_BIT        = 1;

  typedef enum logic [1:0] {
    KIND_TEXT     = 2'd0,
    KIND_DATA     = 2'd1,
    KIND_END_GOOD = 2'd2,
    KIND_END_DROP = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PHASE_OUT     = 2'd0,
    PHASE_IN      = 2'd1,
    PHASE_OVERRUN = 2'd2
  } phase_t;

endpackage

// ===== rtl/core/slip_deframer_auto_detect.sv =====
// slip_deframer_auto_detect: SLIP deframer with text/frame auto detection
// per-byte framing state, unescape logic, output register and skid stage
// depends on slipd_pkg
//
// One received byte is taken per clock cycle when in_stall is low, and its
// result (if any) is registered in the output register or the skid stage. All framing
// work for a byte is one pass of logic from the framing state registers to
// the output register; the output register plus a one-entry skid stage let
// the input keep taking bytes while a result waits. in_stall rises only when
// both are full. Bytes that give no result (non-text ESC, an END that opens
// or closes an empty frame, frame bytes in hide mode) update state. The mode
// register may be written only while the block is idle; there is no
// clearing pass after reset.
module slip_deframer_auto_detect
  import slipd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_data
);

  logic [1:0]       mode_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  phase_t           phase_r, phase_nxt;
  logic             esc_r, esc_nxt;

  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r, out_kind_nxt;
  logic [7:0]       out_data_r, out_data_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  kind_t            skid_kind_r, skid_kind_nxt;
  logic [7:0]       skid_data_r, skid_data_nxt;

  logic             in_fire, out_fire;
  logic             slip_only, hide;
  logic             res_valid;
  kind_t            res_kind;
  logic [7:0]       res_data;

  assign slip_only = mode_r[MODE_FRAMES_ONLY_BIT];
  assign hide      = mode_r[MODE_HIDE_BIT];
  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;

  // framing state update and result for one byte
  always_comb begin
    count_nxt = count_r;
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    res_valid = 1'b0;
    res_kind  = KIND_TEXT;
    res_data  = in_rx_byte;
    if (in_fire) begin
      if (!slip_only && phase_r == PHASE_OUT && in_rx_byte != BYTE_END) begin
        res_valid = 1'b1;
      end else if (in_rx_byte == BYTE_ESC) begin
        esc_nxt = 1'b1;
      end else if (in_rx_byte == BYTE_END) begin
        if (phase_r == PHASE_OVERRUN) begin
          count_nxt = '0;
          phase_nxt = PHASE_OUT;
          esc_nxt   = 1'b0;
          res_valid = !hide;
          res_kind  = KIND_END_DROP;
          res_data  = '0;
        end else if (count_r != '0) begin
          count_nxt = '0;
          phase_nxt = PHASE_OUT;
          esc_nxt   = 1'b0;
          res_valid = !hide;
          res_kind  = KIND_END_GOOD;
          res_data  = '0;
        end else begin
          phase_nxt = (phase_r == PHASE_OUT) ? PHASE_IN : PHASE_OUT;
        end
      end else begin
        if (esc_r) begin
          esc_nxt = 1'b0;
          if (in_rx_byte == BYTE_ESC_END) begin
            res_data = BYTE_END;
          end else if (in_rx_byte == BYTE_ESC_ESC) begin
            res_data = BYTE_ESC;
          end
        end
        if (count_r == CNT_W'(MAX_FRAME - 1)) begin
          count_nxt = '0;
          phase_nxt = PHASE_OVERRUN;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
        res_valid = !hide;
        res_kind  = KIND_DATA;
      end
    end
  end

  // output register and skid stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_kind_nxt  = skid_kind_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = skid_kind_r;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = res_valid;
        skid_kind_nxt  = res_kind;
        skid_data_nxt  = res_data;
      end else begin
        out_valid_nxt = res_valid;
        out_kind_nxt  = res_kind;
        out_data_nxt  = res_data;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_kind_nxt  = res_kind;
      skid_data_nxt  = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= '0;
      count_r      <= '0;
      phase_r      <= PHASE_OUT;
      esc_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      count_r      <= count_nxt;
      phase_r      <= phase_nxt;
      esc_r        <= esc_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_data_r  <= out_data_nxt;
    skid_kind_r <= skid_kind_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a result while output register is empty");

  a_end_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_END_GOOD || out_kind_r == KIND_END_DROP))
      |-> (out_data_r == 8'd0))
    else $error("end marker carries nonzero data");

  a_overrun_close: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_rx_byte == BYTE_END && phase_r == PHASE_OVERRUN)
      |=> (phase_r == PHASE_OUT && count_r == '0 && !esc_r))
    else $error("end after overrun did not return to idle framing state");

  a_skid_stays_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !res_valid && out_valid_r && out_stall) |=> !skid_valid_r)
    else $error("skid stage filled without a new result");

  a_hide_no_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && hide) |-> (res_kind == KIND_TEXT))
    else $error("frame result produced in hide mode");
`endif

endmodule

// ===== sim/slip_deframer_checker.sv =====
// slip_deframer_checker: watches the config port and both channels of the slip deframer,
// predicts every result transfer and compares it with what comes out
// depends on slipd_pkg
`timescale 1ns / 100ps

module slip_deframer_checker
  import slipd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_data,
  output int         fail_count,
  output int         results_left
);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } slip_result_t;

  slip_result_t decoded_q[$];
  logic [1:0]   mode_q = 2'd0;
  int unsigned  frame_len = 0;
  phase_t       phase_q = PHASE_OUT;
  logic         esc_q = 1'b0;
  int           errs = 0;

  function automatic void queue_result(kind_t kind, logic [7:0] data, logic hide);
    slip_result_t r;
    r.kind = kind;
    r.data = data;
    if (!(hide && kind != KIND_TEXT)) decoded_q.push_back(r);
  endfunction

  task automatic unframe_byte(input logic [7:0] rx);
    logic [7:0] b;
    logic       slip_only;
    logic       hide;
    b = rx;
    slip_only = mode_q[MODE_FRAMES_ONLY_BIT];
    hide = mode_q[MODE_HIDE_BIT];
    if (!slip_only && phase_q == PHASE_OUT && b != BYTE_END) begin
      queue_result(KIND_TEXT, b, hide);
    end else if (b == BYTE_ESC) begin
      esc_q = 1'b1;
    end else if (b == BYTE_END) begin
      if (phase_q == PHASE_OVERRUN) begin
        frame_len = 0;
        phase_q = PHASE_OUT;
        esc_q = 1'b0;
        queue_result(KIND_END_DROP, 8'h00, hide);
      end else if (frame_len > 0) begin
        frame_len = 0;
        phase_q = PHASE_OUT;
        esc_q = 1'b0;
        queue_result(KIND_END_GOOD, 8'h00, hide);
      end else begin
        // empty frame: END only flips in and out
        phase_q = (phase_q == PHASE_OUT) ? PHASE_IN : PHASE_OUT;
      end
    end else begin
      if (esc_q) begin
        esc_q = 1'b0;
        if (b == BYTE_ESC_END) b = BYTE_END;
        else if (b == BYTE_ESC_ESC) b = BYTE_ESC;
      end
      frame_len++;
      if (frame_len >= MAX_FRAME) begin
        frame_len = 0;
        phase_q = PHASE_OVERRUN;
      end
      queue_result(KIND_DATA, b, hide);
    end
  endtask

  always @(posedge clk) begin : watch
    slip_result_t head;
    if (!rst_n) begin
      mode_q = 2'd0;
      frame_len = 0;
      phase_q = PHASE_OUT;
      esc_q = 1'b0;
      decoded_q.delete();
    end else begin
      if (cfg_wr_en) mode_q = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          if (errs < 10)
            $display("%0t: unexpected result transfer kind %0d data %02h",
                     $realtime, out_kind, out_data);
          errs++;
        end else begin
          head = decoded_q.pop_front();
          if (out_kind !== head.kind || out_data !== head.data) begin
            if (errs < 10)
              $display("%0t: mismatch, expected kind %0d data %02h, got kind %0d data %02h",
                       $realtime, head.kind, head.data, out_kind, out_data);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) unframe_byte(in_rx_byte);
    end
    results_left <= decoded_q.size();
    fail_count <= errs;
  end

endmodule

// ===== sim/slip_deframer_auto_detect_test.sv =====
// slip_deframer_auto_detect_test: stimulus, idling and verdict for the slip deframer
// drives serial bytes and mode writes, the checker predicts and compares
// depends on slipd_pkg, slip_deframer_auto_detect and slip_deframer_checker
`timescale 1ns / 100ps

module slip_deframer_auto_detect_test;
  import slipd_pkg::*;

  localparam logic [1:0] MODE_AUTO        = 2'd0;
  localparam logic [1:0] MODE_FRAMED      = 2'd1;
  localparam logic [1:0] MODE_HIDE        = 2'd2;
  localparam logic [1:0] MODE_FRAMED_HIDE = 2'd3;
  localparam int         QUIET_LIMIT      = 5000;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = 2'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_data;
  logic       steady = 1'b0;
  int         fail_count;
  int         results_left;
  int         bytes_sent = 0;
  int         quiet = 0;

  logic [7:0] opening_bytes [20] = '{
    8'h00, 8'hFF, 8'h55, BYTE_ESC, BYTE_END, BYTE_END, BYTE_END, 8'h00, 8'hFF, BYTE_ESC,
    BYTE_ESC_END, BYTE_ESC, BYTE_ESC_ESC, BYTE_ESC, 8'h41, BYTE_ESC, BYTE_END, BYTE_END,
    BYTE_ESC, BYTE_END
  };

  logic [1:0] mode_plan [7] = '{
    MODE_FRAMED, MODE_HIDE, MODE_FRAMED_HIDE, MODE_AUTO, MODE_HIDE, MODE_FRAMED, MODE_AUTO
  };

  slip_deframer_auto_detect i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rx_byte  (in_rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_data    (out_data)
  );

  slip_deframer_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .results_left (results_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 13);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == BYTE_END || b == BYTE_ESC) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_left != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one decoded byte: plain, or an escape pair
  task automatic send_unit();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      send_byte(BYTE_ESC);
      case ($urandom_range(0, 2))
        0: send_byte(BYTE_ESC_END);
        1: send_byte(BYTE_ESC_ESC);
        default: send_byte(plain_byte());
      endcase
    end else begin
      send_byte(plain_byte());
    end
  endtask

  task automatic send_frame(input int units);
    send_byte(BYTE_END);
    repeat (units) send_unit();
    send_byte(BYTE_END);
  endtask

  task automatic send_plain_frame(input int len);
    send_byte(BYTE_END);
    repeat (len) send_byte(plain_byte());
    send_byte(BYTE_END);
  endtask

  task automatic run_traffic(input int n);
    int goal;
    int r;
    goal = bytes_sent + n;
    while (bytes_sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        if ($urandom_range(0, 3) == 0) send_frame($urandom_range(0, 40));
        else send_frame($urandom_range(0, 8));
      end else if (r < 75) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        // broken sequences: markers in odd places
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 4))
            0: send_byte(BYTE_END);
            1: send_byte(BYTE_ESC);
            2: send_byte(BYTE_ESC_END);
            3: send_byte(BYTE_ESC_ESC);
            default: send_byte(8'($urandom_range(0, 255)));
          endcase
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_mode(MODE_AUTO);
    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
    wait_results_done();
    // frame that just reaches the size limit, so it ends in overrun
    send_plain_frame(MAX_FRAME);
    wait_results_done();
    for (int p = 0; p < 7; p++) begin
      set_mode(mode_plan[p]);
      steady <= (p == 3);
      run_traffic(60);
      wait_results_done();
    end
    repeat (16) @(posedge clk);
    if (fail_count == 0 && results_left == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/slipd_pkg.sv
rtl/core/slip_deframer_auto_detect.sv
sim/slip_deframer_checker.sv
sim/slip_deframer_auto_detect_test.sv
